// ===== rtl/prq_pkg.sv =====
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants of the process ready queue: operation and status
// codes, fixed result field widths and the per-cell command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package prq_pkg;

   localparam int QueueDepthDefault   = 16;
   localparam int IndexBitsDefault    = 8;
   localparam int PriorityBitsDefault = 8;

   localparam int OperationBits = 2;
   localparam int StatusBits    = 2;
   localparam int RemovedBits   = 8;
   localparam int OccupancyBits = 5;

   typedef enum logic [OperationBits-1:0] {
      OP_SORTED_INSERT = 2'd0,
      OP_TAIL_INSERT   = 2'd1,
      OP_REMOVE_HEAD   = 2'd2,
      OP_RENUMBER      = 2'd3
   } op_type;

   typedef enum logic [StatusBits-1:0] {
      ST_DONE       = 2'd0,
      ST_EMPTY_POP  = 2'd1,
      ST_FULL_DROP  = 2'd2
   } status_type;

   // command broadcast to every cell of the chain in the same cycle
   typedef struct packed {
      logic insert_en;
      logic tail_mode;
      logic remove_en;
      logic renumber_en;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/prq_req_if.sv =====
// ----------------------------------------------------------------------------
// prq_req_if
// Request channel of the ready queue: valid/ready handshake with operation,
// process index and priority.
// ----------------------------------------------------------------------------
`default_nettype none

interface prq_req_if #(
   parameter int INDEX_BITS    = prq_pkg::IndexBitsDefault,
   parameter int PRIORITY_BITS = prq_pkg::PriorityBitsDefault
);
   logic                             valid;
   logic                             ready;
   logic [prq_pkg::OperationBits-1:0] operation;
   logic [INDEX_BITS-1:0]            process_index;
   logic [PRIORITY_BITS-1:0]         priority_req;

   modport source (output valid, operation, process_index, priority_req, input ready);
   modport sink   (input valid, operation, process_index, priority_req, output ready);
endinterface

`default_nettype wire

// ===== rtl/prq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// prq_rsp_if
// Response channel of the ready queue: valid/ready handshake with status,
// popped index, empty flag and occupancy.
// ----------------------------------------------------------------------------
`default_nettype none

interface prq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [prq_pkg::StatusBits-1:0]    status;
   logic [prq_pkg::RemovedBits-1:0]   removed_index;
   logic                              is_empty;
   logic [prq_pkg::OccupancyBits-1:0] occupancy;

   modport source (output valid, status, removed_index, is_empty, occupancy, input ready);
   modport sink   (input valid, status, removed_index, is_empty, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/prq_cell.sv =====
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the sorted chain. Holds an (index, priority) entry and, under
// the broadcast command, keeps it, loads the new word, takes its left
// neighbor's (insert) or right neighbor's entry (pop), or renumbers its index.
// ----------------------------------------------------------------------------
`default_nettype none

module prq_cell #(
   parameter int INDEX_BITS    = prq_pkg::IndexBitsDefault,
   parameter int PRIORITY_BITS = prq_pkg::PriorityBitsDefault
) (
   input  wire                         clock,
   input  prq_pkg::cell_ctrl_type      ctrl,
   input  wire                         occupied,
   input  wire  [INDEX_BITS-1:0]       new_index,
   input  wire  [PRIORITY_BITS-1:0]    new_priority,
   input  wire  [INDEX_BITS-1:0]       left_index,
   input  wire  [PRIORITY_BITS-1:0]    left_priority,
   input  wire  [INDEX_BITS-1:0]       right_index,
   input  wire  [PRIORITY_BITS-1:0]    right_priority,
   input  wire                         shift_in,
   output logic                        shift_out,
   output logic [INDEX_BITS-1:0]       index_out,
   output logic [PRIORITY_BITS-1:0]    priority_out
);
   import prq_pkg::*;

   logic [INDEX_BITS-1:0]    index_ff;
   logic [INDEX_BITS-1:0]    index_in;
   logic [PRIORITY_BITS-1:0] priority_ff;
   logic [PRIORITY_BITS-1:0] priority_in;
   logic                     keep;

   // entry stays ahead of the new word: occupied and, unless in tail mode, not of larger priority
   assign keep      = occupied && (ctrl.tail_mode || (priority_ff <= new_priority));
   assign shift_out = shift_in || !keep;

   always_comb begin
      index_in    = index_ff;
      priority_in = priority_ff;
      if (ctrl.insert_en) begin
         if (shift_in) begin
            index_in    = left_index;
            priority_in = left_priority;
         end else if (!keep) begin
            index_in    = new_index;
            priority_in = new_priority;
         end
      end else if (ctrl.remove_en) begin
         index_in    = right_index;
         priority_in = right_priority;
      end else if (ctrl.renumber_en && occupied && (index_ff > new_index)) begin
         index_in = index_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      index_ff    <= index_in;
      priority_ff <= priority_in;
   end

   assign index_out    = index_ff;
   assign priority_out = priority_ff;

endmodule

`default_nettype wire

// ===== rtl/priority_ready_queue.sv =====
// ----------------------------------------------------------------------------
// priority_ready_queue
// Bounded process ready queue kept as a sorted chain of cells.
//
// Usage: words arrive on req_bus (operation, process_index, priority_req) and
// each accepted word yields exactly one word on rsp_bus (status,
// removed_index, is_empty, occupancy). Sorted insert places the entry behind
// every entry of lower or equal priority, tail insert appends, remove pops
// the head, renumber decrements every stored index above the given one.
// All cells act in the same cycle; the response is valid the cycle after
// acceptance and one word is taken every cycle while rsp_bus.ready stays
// high; the single response register sits between request and response. While
// a response stalls, req_bus.ready drops and the queue holds its contents.
// Insert into a full queue is dropped with status full; remove on an empty
// queue returns status empty with index 0.
// Reset (synchronous) empties the queue and drops any pending response;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ready_queue #(
   parameter int QUEUE_DEPTH   = prq_pkg::QueueDepthDefault,
   parameter int INDEX_BITS    = prq_pkg::IndexBitsDefault,
   parameter int PRIORITY_BITS = prq_pkg::PriorityBitsDefault
) (
   input  wire       clock,
   input  wire       reset,
   prq_req_if.sink   req_bus,
   prq_rsp_if.source rsp_bus
);
   import prq_pkg::*;

   localparam int CountBits = $clog2(QUEUE_DEPTH + 1);

   logic [CountBits-1:0]     count_ff;
   logic [CountBits-1:0]     count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [RemovedBits-1:0]   removed_ff;
   logic [RemovedBits-1:0]   removed_in;

   op_type                   op;
   logic                     accept;
   logic                     full;
   logic                     empty;
   cell_ctrl_type            ctrl;
   logic [INDEX_BITS-1:0]    new_index;
   logic [PRIORITY_BITS-1:0] new_priority;

   logic [QUEUE_DEPTH-1:0]   occupied;
   logic [QUEUE_DEPTH:0]     shift_chain;
   logic [INDEX_BITS-1:0]    cell_index    [QUEUE_DEPTH];
   logic [PRIORITY_BITS-1:0] cell_priority [QUEUE_DEPTH];

   assign op           = op_type'(req_bus.operation);
   assign new_index    = INDEX_BITS'(req_bus.process_index);
   assign new_priority = PRIORITY_BITS'(req_bus.priority_req);
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept       = req_bus.valid && req_bus.ready;
   assign full         = (count_ff == CountBits'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);
   assign shift_chain[0] = 1'b0;

   genvar k;
   generate
      for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
         logic [INDEX_BITS-1:0]    left_index;
         logic [PRIORITY_BITS-1:0] left_priority;
         logic [INDEX_BITS-1:0]    right_index;
         logic [PRIORITY_BITS-1:0] right_priority;

         assign occupied[k] = (CountBits'(k) < count_ff);

         if (k == 0) begin : g_head
            assign left_index    = new_index;
            assign left_priority = new_priority;
         end else begin : g_body
            assign left_index    = cell_index[k-1];
            assign left_priority = cell_priority[k-1];
         end

         if (k == QUEUE_DEPTH - 1) begin : g_tail
            assign right_index    = '0;
            assign right_priority = '0;
         end else begin : g_inner
            assign right_index    = cell_index[k+1];
            assign right_priority = cell_priority[k+1];
         end

         prq_cell #(
            .INDEX_BITS    (INDEX_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
         ) u_cell (
            .clock          (clock),
            .ctrl           (ctrl),
            .occupied       (occupied[k]),
            .new_index      (new_index),
            .new_priority   (new_priority),
            .left_index     (left_index),
            .left_priority  (left_priority),
            .right_index    (right_index),
            .right_priority (right_priority),
            .shift_in       (shift_chain[k]),
            .shift_out      (shift_chain[k+1]),
            .index_out      (cell_index[k]),
            .priority_out   (cell_priority[k])
         );
      end
   endgenerate

   always_comb begin
      ctrl       = '0;
      status_in  = ST_DONE;
      removed_in = '0;
      count_in   = count_ff;
      case (op)
         OP_SORTED_INSERT, OP_TAIL_INSERT: begin
            ctrl.tail_mode = (op == OP_TAIL_INSERT);
            if (full) begin
               status_in = ST_FULL_DROP;
            end else begin
               ctrl.insert_en = accept;
               count_in       = count_ff + 1'b1;
            end
         end
         OP_REMOVE_HEAD: begin
            if (empty) begin
               status_in = ST_EMPTY_POP;
            end else begin
               ctrl.remove_en = accept;
               removed_in     = RemovedBits'(cell_index[0]);
               count_in       = count_ff - 1'b1;
            end
         end
         OP_RENUMBER: begin
            ctrl.renumber_en = accept;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // hold the response payload until a new word is accepted
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = status_ff;
   assign rsp_bus.removed_index = removed_ff;
   assign rsp_bus.is_empty      = (count_ff == '0);
   assign rsp_bus.occupancy     = OccupancyBits'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountBits'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (count_ff == '0) && !rsp_valid_ff)
      else $error("reset did not empty the queue");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_REMOVE_HEAD) && !empty
      |=> count_ff == CountBits'($past(count_ff) - 1'b1))
      else $error("pop did not shrink the queue");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == ST_FULL_DROP) |-> full)
      else $error("full drop reported on a queue that is not full");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_bus.ready |=> $stable(count_ff))
      else $error("queue changed while the response stalled");

endmodule

`default_nettype wire

// ===== tb/sv/ready_queue_check.sv =====
// ----------------------------------------------------------------------------
// ready_queue_check
// Watches both channels of the ready queue. Keeps its own sorted copy of the
// queue, works out the response word due for every accepted request word,
// and compares each accepted response word field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ready_queue_check #(
   parameter int QUEUE_DEPTH = prq_pkg::QueueDepthDefault
) (
   input  wire  clock,
   input  wire  reset,
   prq_req_if   req_mon,
   prq_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int IndexW    = prq_pkg::IndexBitsDefault;
   localparam int PriorityW = prq_pkg::PriorityBitsDefault;

   typedef struct packed {
      status_type               status;
      logic [RemovedBits-1:0]   removed_index;
      logic                     is_empty;
      logic [OccupancyBits-1:0] occupancy;
   } queue_result_type;

   logic [IndexW-1:0]    slot_index    [QUEUE_DEPTH];
   logic [PriorityW-1:0] slot_priority [QUEUE_DEPTH];
   int                   fill;
   queue_result_type     due_words [$];

   task automatic flag_error(input string what);
      $display("%0t ns: response mismatch, %s", $time, what);
      error_count++;
   endtask

   // apply one request word to the local queue and return the response it earns
   task automatic predict_word(input op_type op, input logic [IndexW-1:0] pidx,
                               input logic [PriorityW-1:0] prio,
                               output queue_result_type res);
      int pos;
      res.status        = ST_DONE;
      res.removed_index = '0;
      case (op)
         OP_SORTED_INSERT, OP_TAIL_INSERT: begin
            if (fill >= QUEUE_DEPTH) begin
               res.status = ST_FULL_DROP;
            end else begin
               pos = 0;
               if (op == OP_TAIL_INSERT) begin
                  pos = fill;
               end else begin
                  // walk past every entry of lower or equal priority
                  while (pos < fill && slot_priority[pos] <= prio) pos++;
               end
               for (int k = fill; k > pos; k--) begin
                  slot_index[k]    = slot_index[k-1];
                  slot_priority[k] = slot_priority[k-1];
               end
               slot_index[pos]    = pidx;
               slot_priority[pos] = prio;
               fill++;
            end
         end
         OP_REMOVE_HEAD: begin
            if (fill == 0) begin
               res.status = ST_EMPTY_POP;
            end else begin
               res.removed_index = slot_index[0];
               for (int k = 1; k < fill; k++) begin
                  slot_index[k-1]    = slot_index[k];
                  slot_priority[k-1] = slot_priority[k];
               end
               fill--;
            end
         end
         OP_RENUMBER: begin
            for (int k = 0; k < fill; k++) begin
               if (slot_index[k] > pidx) slot_index[k] = slot_index[k] - 1'b1;
            end
         end
         default: ;
      endcase
      res.is_empty  = (fill == 0);
      res.occupancy = fill[OccupancyBits-1:0];
   endtask

   always @(posedge clock) begin : watch
      queue_result_type want;
      if (reset) begin
         fill = 0;
         due_words.delete();
      end else begin
         // take the request first so a response in the same cycle still lines up
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            predict_word(op_type'(req_mon.operation), req_mon.process_index,
                         req_mon.priority_req, want);
            due_words.push_back(want);
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_words.size() == 0) begin
               flag_error("response word with nothing outstanding");
            end else begin
               want = due_words.pop_front();
               if (rsp_mon.status !== want.status)
                  flag_error($sformatf("status got %0d want %0d",
                                       rsp_mon.status, want.status));
               if (rsp_mon.removed_index !== want.removed_index)
                  flag_error($sformatf("removed_index got %0d want %0d",
                                       rsp_mon.removed_index, want.removed_index));
               if (rsp_mon.is_empty !== want.is_empty)
                  flag_error($sformatf("is_empty got %0d want %0d",
                                       rsp_mon.is_empty, want.is_empty));
               if (rsp_mon.occupancy !== want.occupancy)
                  flag_error($sformatf("occupancy got %0d want %0d",
                                       rsp_mon.occupancy, want.occupancy));
            end
         end
      end
      pending_count = due_words.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the process ready queue. Runs a short directed
// sequence (empty pop, ties, tail insert, renumber edges, filling to full),
// then random phases that swing between filling and draining, with random
// gaps on both channels, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prq_pkg::*;

   localparam int ItemTotal     = 1150;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 2000;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   stall_cycles;
   bit   sender_gaps = 1'b1;
   bit   sink_gaps   = 1'b1;
   bit   hold_rsp    = 1'b0;

   prq_req_if req_bus ();
   prq_rsp_if rsp_bus ();

   priority_ready_queue uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ready_queue_check queue_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input op_type op, input logic [7:0] pidx,
                            input logic [7:0] prio);
      while (sender_gaps && $urandom_range(99) < 33) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.process_index <= pidx;
      req_bus.priority_req  <= prio;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // response side: random gaps, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_bus.ready <= !(sink_gaps && $urandom_range(99) < 33);
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      op_type      op;
      logic [7:0]  pidx;
      logic [7:0]  prio;
      int unsigned pick;
      int unsigned mode;
      int          phase_left;
      int          sent;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_SORTED_INSERT;
      req_bus.process_index <= '0;
      req_bus.priority_req  <= '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: pop on empty, priority extremes, ties, tail, renumber edges
      send_word(OP_REMOVE_HEAD,   8'd0,   8'd0);
      send_word(OP_SORTED_INSERT, 8'd0,   8'd255);
      send_word(OP_SORTED_INSERT, 8'd255, 8'd0);
      send_word(OP_SORTED_INSERT, 8'd10,  8'd5);
      send_word(OP_SORTED_INSERT, 8'd11,  8'd5);
      send_word(OP_TAIL_INSERT,   8'd200, 8'd0);
      send_word(OP_RENUMBER,      8'd10,  8'd0);
      send_word(OP_RENUMBER,      8'd255, 8'd255);
      send_word(OP_RENUMBER,      8'd0,   8'd0);
      send_word(OP_REMOVE_HEAD,   8'd0,   8'd0);
      // fill to the brim, then push twice into a full queue
      for (int k = 0; k < 12; k++) begin
         send_word((k % 2) ? OP_TAIL_INSERT : OP_SORTED_INSERT,
                   8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      send_word(OP_SORTED_INSERT, 8'd77, 8'd1);
      send_word(OP_TAIL_INSERT,   8'd78, 8'd1);
      sent = 24;

      phase_left = 0;
      mode       = 0;
      for (; sent < ItemTotal; sent++) begin
         if (phase_left == 0) begin
            mode       = $urandom_range(2);
            phase_left = $urandom_range(10, 60);
         end
         phase_left--;
         if (sent == 300) hold_rsp = 1'b1;
         if (sent == 600) wait_for_drain();
         if (sent == 700) begin
            sender_gaps = 1'b0;
            sink_gaps   = 1'b0;
         end
         if (sent == 900) begin
            sender_gaps = 1'b1;
            sink_gaps   = 1'b1;
         end

         // mode 0 fills, mode 1 drains, mode 2 stays balanced
         pick = $urandom_range(99);
         case (mode)
            0:       pick = (pick < 45) ? 0 : (pick < 70) ? 1 : (pick < 85) ? 2 : 3;
            1:       pick = (pick < 15) ? 0 : (pick < 25) ? 1 : (pick < 85) ? 2 : 3;
            default: pick = (pick < 30) ? 0 : (pick < 45) ? 1 : (pick < 85) ? 2 : 3;
         endcase
         case (pick)
            0:       op = OP_SORTED_INSERT;
            1:       op = OP_TAIL_INSERT;
            2:       op = OP_REMOVE_HEAD;
            default: op = OP_RENUMBER;
         endcase
         // narrow ranges make ties and renumber hits common
         pidx = ($urandom_range(1) == 0) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
         prio = ($urandom_range(1) == 0) ? 8'($urandom_range(7))  : 8'($urandom_range(255));
         send_word(op, pidx, prio);
      end

      wait_for_drain();
      repeat (4) @(negedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/prq_pkg.sv
rtl/prq_req_if.sv
rtl/prq_rsp_if.sv
rtl/prq_cell.sv
rtl/priority_ready_queue.sv
tb/sv/ready_queue_check.sv
tb/sv/tb.sv
